// ===== hw/rtl/brfo_pkg.sv =====
// Shared types, constants and helpers of the byte ring FIFO with overwrite.
// No dependencies; used by the channel interfaces and the top level.

package brfo_pkg;

   localparam int DEPTH      = 4096;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int MIN_CAP    = 64;
   localparam int DATA_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [DATA_W-1:0] byte_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_CAPACITY = '0;

   localparam count_type MIN_CAP_C = count_type'(MIN_CAP);
   localparam count_type DEPTH_C   = count_type'(DEPTH);

   typedef enum logic [1:0] {
      MODE_PUSH     = 2'd0,
      MODE_PUSH_OVR = 2'd1,
      MODE_POP      = 2'd2,
      MODE_FLUSH    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   // Written capacity is held between the minimum ring size and the memory depth.
   function automatic count_type clamp_capacity(input count_type value);
      count_type result;
      result = value;
      if (value < MIN_CAP_C) begin
         result = MIN_CAP_C;
      end else if (value > DEPTH_C) begin
         result = DEPTH_C;
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/brfo_req_if.sv =====
// Request channel of the byte ring FIFO: valid/ready handshake and payload.
// Depends on brfo_pkg.

interface brfo_req_if;
   logic                valid;
   logic                ready;
   brfo_pkg::mode_type  mode;
   brfo_pkg::byte_type  data_in;
   logic                last;

   modport source (output valid, output mode, output data_in, output last, input ready);
   modport sink   (input valid, input mode, input data_in, input last, output ready);
endinterface

// ===== hw/rtl/brfo_rsp_if.sv =====
// Response channel of the byte ring FIFO: valid/ready handshake and payload.
// Depends on brfo_pkg.

interface brfo_rsp_if;
   logic                valid;
   logic                ready;
   brfo_pkg::byte_type  data_out;
   logic                done_res;
   brfo_pkg::count_type used_count;
   brfo_pkg::count_type free_space;
   logic                transfer_end;

   modport source (output valid, output data_out, output done_res, output used_count,
                   output free_space, output transfer_end, input ready);
   modport sink   (input valid, input data_out, input done_res, input used_count,
                   input free_space, input transfer_end, output ready);
endinterface

// ===== hw/rtl/brfo_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.

module brfo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/byte_ring_fifo_overwrite.sv =====
// Top level of the byte ring FIFO with overwrite-oldest push.
// Depends on brfo_pkg, brfo_req_if, brfo_rsp_if and brfo_ram.

// For a push, an overwriting push, a flush and a pop of an empty ring, the
// response is registered at the edge that accepts the request. A pop that
// delivers a byte reads a single-port RAM with a registered read and then
// registers the byte from the read state, and the request side is held off in
// the read state. A new request is accepted only when the output register is
// empty or its response is taken at the same edge, so a response that is left
// waiting stalls the request side. The byte store needs no clearing after
// reset. Writing capacity (register 0, byte address 0) clamps it to 64..4096
// and empties the ring; it must be written only while the block is idle.

module byte_ring_fifo_overwrite (
   input  logic                                 clock,
   input  logic                                 reset,
   brfo_req_if.sink                             req,
   brfo_rsp_if.source                           rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [brfo_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [brfo_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [brfo_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   brfo_pkg::state_type state_ff, state_in;
   brfo_pkg::count_type capacity_ff, capacity_in;
   brfo_pkg::count_type held_ff, held_in;
   brfo_pkg::addr_type  rd_idx_ff, rd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   brfo_pkg::byte_type  rsp_data_ff, rsp_data_in;
   logic                rsp_done_ff, rsp_done_in;
   brfo_pkg::count_type rsp_used_ff, rsp_used_in;
   brfo_pkg::count_type rsp_free_ff, rsp_free_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                cfg_write;
   logic                full;
   logic                empty;
   brfo_pkg::count_type wp_sum;
   brfo_pkg::count_type wp_wrap;
   brfo_pkg::count_type rd_next_sum;
   brfo_pkg::addr_type  rd_next;
   logic                ram_we;
   brfo_pkg::addr_type  ram_addr;
   brfo_pkg::byte_type  ram_rdata;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == brfo_pkg::CSR_ADDR_CAPACITY);
   assign csr_prdata = (csr_paddr == brfo_pkg::CSR_ADDR_CAPACITY)
                       ? {{(brfo_pkg::CSR_DATA_W - brfo_pkg::CNT_W){1'b0}}, capacity_ff}
                       : '0;

   assign req.ready = (state_ff == brfo_pkg::S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   assign full  = (held_ff == capacity_ff);
   assign empty = (held_ff == '0);

   // Write point is the read point plus the fill, folded once into the ring.
   assign wp_sum  = {1'b0, rd_idx_ff} + held_ff;
   assign wp_wrap = (wp_sum >= capacity_ff) ? (wp_sum - capacity_ff) : wp_sum;

   assign rd_next_sum = {1'b0, rd_idx_ff} + brfo_pkg::count_type'(1);
   assign rd_next     = (rd_next_sum >= capacity_ff)
                        ? '0 : rd_next_sum[brfo_pkg::ADDR_W-1:0];

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = wp_wrap[brfo_pkg::ADDR_W-1:0];
      if (accept) begin
         case (req.mode)
            brfo_pkg::MODE_PUSH:     ram_we = !full;
            brfo_pkg::MODE_PUSH_OVR: ram_we = 1'b1;
            brfo_pkg::MODE_POP:      ram_addr = rd_idx_ff;
            brfo_pkg::MODE_FLUSH:    ram_we = 1'b0;
            default:                 ram_we = 1'b0;
         endcase
      end
   end

   brfo_ram #(
      .WIDTH (brfo_pkg::DATA_W),
      .DEPTH (brfo_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req.data_in),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      capacity_in  = capacity_ff;
      held_in      = held_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_free_in  = rsp_free_ff;
      rsp_last_in  = rsp_last_ff;

      if (cfg_write) begin
         capacity_in = brfo_pkg::clamp_capacity(csr_pwdata[brfo_pkg::CNT_W-1:0]);
         held_in     = '0;
         rd_idx_in   = '0;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_done_in  = 1'b0;
         rsp_last_in  = req.last;
         case (req.mode)
            brfo_pkg::MODE_PUSH: begin
               if (!full) begin
                  held_in     = held_ff + brfo_pkg::count_type'(1);
                  rsp_done_in = 1'b1;
               end
            end
            brfo_pkg::MODE_PUSH_OVR: begin
               if (!full) begin
                  held_in = held_ff + brfo_pkg::count_type'(1);
               end else begin
                  rd_idx_in = rd_next;
               end
               rsp_done_in = 1'b1;
            end
            brfo_pkg::MODE_POP: begin
               if (!empty) begin
                  held_in      = held_ff - brfo_pkg::count_type'(1);
                  rd_idx_in    = rd_next;
                  rsp_done_in  = 1'b1;
                  rsp_valid_in = 1'b0;
                  state_in     = brfo_pkg::S_READ;
               end
            end
            brfo_pkg::MODE_FLUSH: begin
               held_in = '0;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
         rsp_used_in = held_in;
         rsp_free_in = capacity_ff - held_in;
      end else if (state_ff == brfo_pkg::S_READ) begin
         // The popped byte arrives from the RAM's registered read in the cycle after the read.
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rdata;
         state_in     = brfo_pkg::S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brfo_pkg::S_IDLE;
         capacity_ff  <= brfo_pkg::DEPTH_C;
         held_ff      <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         held_ff      <= held_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
      rsp_used_ff <= rsp_used_in;
      rsp_free_ff <= rsp_free_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.data_out     = rsp_data_ff;
   assign rsp.done_res     = rsp_done_ff;
   assign rsp.used_count   = rsp_used_ff;
   assign rsp.free_space   = rsp_free_ff;
   assign rsp.transfer_end = rsp_last_ff;

   // The fill never exceeds the ring size.
   assert property (@(posedge clock) disable iff (reset) held_ff <= capacity_ff)
      else $error("held count exceeds capacity");

   // The read point always lies inside the ring.
   assert property (@(posedge clock) disable iff (reset)
                    {1'b0, rd_idx_ff} < capacity_ff)
      else $error("read index outside the ring");

   // A pending pop presents its response on the following cycle, unless a capacity write comes in between.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == brfo_pkg::S_READ) |=> rsp_valid_ff)
      else $error("pop response not presented after RAM read");

endmodule
